/* src/wlq_pkg.sv */
// shared types, constants and helpers for the wide line to quad expansion
// no dependencies
`default_nettype none

package wlq_pkg;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned WidthW  = 31;
  localparam int unsigned DiffW   = 33;
  localparam int unsigned NormW   = 31;
  localparam int unsigned SqW     = 2 * NormW;
  localparam int unsigned SumW    = SqW + 1;
  localparam int unsigned RootW   = 32;
  localparam int unsigned UnitW   = 31;
  localparam int unsigned UnitSh  = 30;
  localparam int unsigned ProdW   = UnitW + WidthW;
  localparam int unsigned MagW    = 32;
  localparam int unsigned OffW    = MagW + 1;
  localparam int unsigned CornerW = CoordW + 2;

  // item data that rides alongside the arithmetic
  typedef struct packed {
    logic signed [CoordW-1:0] sx;
    logic signed [CoordW-1:0] sy;
    logic signed [CoordW-1:0] ex;
    logic signed [CoordW-1:0] ey;
    logic [WidthW-1:0]        w;
    logic                     neg_x;
    logic                     neg_y;
    logic                     deg;
  } side_t;

  function automatic logic signed [CoordW-1:0] sat32(input logic signed [CornerW-1:0] v);
    logic signed [CornerW-1:0] hi;
    logic signed [CornerW-1:0] lo;
    hi = CornerW'(signed'(33'sh0_7FFF_FFFF));
    lo = -hi - CornerW'(1);
    if (v > hi) begin
      return hi[CoordW-1:0];
    end else if (v < lo) begin
      return lo[CoordW-1:0];
    end
    return v[CoordW-1:0];
  endfunction

endpackage

`default_nettype wire

/* src/wlq_front.sv */
// front end: direction, half width, normalizing shift and squares
// uses wlq_pkg
`default_nettype none

module wlq_front import wlq_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     en,
  input  wire logic                     in_v,
  input  wire logic signed [CoordW-1:0] start_x,
  input  wire logic signed [CoordW-1:0] start_y,
  input  wire logic signed [CoordW-1:0] end_x,
  input  wire logic signed [CoordW-1:0] end_y,
  input  wire logic [WidthW-1:0]        line_width,
  input  wire logic [WidthW-1:0]        min_hw,
  output logic                          o_v,
  output logic [SumW-1:0]               o_n,
  output logic [NormW-1:0]              o_ax,
  output logic [NormW-1:0]              o_ay,
  output side_t                         o_side
);

  logic              v1, v2, v3, v4;
  side_t             side1, side2, side3, side4;
  logic [DiffW-1:0]  ax1, ay1, ax2, ay2;
  logic [4:0]        sl2;
  logic [1:0]        sr2;
  logic [NormW-1:0]  ax3, ay3, ax4, ay4;
  logic [SqW-1:0]    sqx4, sqy4;

  logic signed [DiffW-1:0] dx, dy;
  logic [WidthW-1:0]       half;
  logic [DiffW-1:0]        orv;
  logic [5:0]              msb;
  logic [63:0]             shx, shy;

  always_comb begin
    dx   = DiffW'(end_x) - DiffW'(start_x);
    dy   = DiffW'(end_y) - DiffW'(start_y);
    half = {1'b0, line_width[WidthW-1:1]};
  end

  // highest set bit of the combined magnitude
  always_comb begin
    orv = ax1 | ay1;
    msb = '0;
    for (int i = 0; i < DiffW; i++) begin
      if (orv[i]) begin
        msb = 6'(i);
      end
    end
  end

  always_comb begin
    shx = (64'(ax2) << sl2) >> sr2;
    shy = (64'(ay2) << sl2) >> sr2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      o_v <= 1'b0;
    end else if (en) begin
      v1 <= in_v;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      o_v <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1.sx    <= start_x;
      side1.sy    <= start_y;
      side1.ex    <= end_x;
      side1.ey    <= end_y;
      side1.w     <= (half < min_hw) ? min_hw : half;
      side1.neg_x <= (dy > 0);
      side1.neg_y <= (dx < 0);
      side1.deg   <= (dx == 0) && (dy == 0);
      ax1 <= dx[DiffW-1] ? DiffW'(-dx) : DiffW'(dx);
      ay1 <= dy[DiffW-1] ? DiffW'(-dy) : DiffW'(dy);

      side2 <= side1;
      ax2   <= ax1;
      ay2   <= ay1;
      if (msb >= 6'(UnitSh)) begin
        sl2 <= '0;
        sr2 <= 2'(msb - 6'(UnitSh));
      end else begin
        sl2 <= 5'(6'(UnitSh) - msb);
        sr2 <= '0;
      end

      side3 <= side2;
      ax3   <= shx[NormW-1:0];
      ay3   <= shy[NormW-1:0];

      side4 <= side3;
      ax4   <= ax3;
      ay4   <= ay3;
      sqx4  <= SqW'(ax3) * SqW'(ax3);
      sqy4  <= SqW'(ay3) * SqW'(ay3);

      o_side <= side4;
      o_ax   <= ax4;
      o_ay   <= ay4;
      o_n    <= SumW'(sqx4) + SumW'(sqy4);
    end
  end

endmodule

`default_nettype wire

/* src/wlq_sqrt.sv */
// pipelined integer square root, one root bit per stage
// uses wlq_pkg
`default_nettype none

module wlq_sqrt import wlq_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_v,
  input  wire logic [SumW-1:0]   in_n,
  input  wire logic [NormW-1:0]  in_ax,
  input  wire logic [NormW-1:0]  in_ay,
  input  side_t                  in_side,
  output logic                   o_v,
  output logic [RootW-1:0]       o_len,
  output logic [NormW-1:0]       o_ax,
  output logic [NormW-1:0]       o_ay,
  output side_t                  o_side
);

  localparam int unsigned NW = 2 * RootW;
  localparam int unsigned RW = RootW + 3;

  logic              v   [0:RootW];
  logic [NW-1:0]     n   [0:RootW];
  logic [RW-1:0]     r   [0:RootW];
  logic [RootW-1:0]  q   [0:RootW];
  logic [NormW-1:0]  ax  [0:RootW];
  logic [NormW-1:0]  ay  [0:RootW];
  side_t             sd  [0:RootW];

  always_comb begin
    v[0]  = in_v;
    n[0]  = NW'(in_n);
    r[0]  = '0;
    q[0]  = '0;
    ax[0] = in_ax;
    ay[0] = in_ay;
    sd[0] = in_side;
  end

  for (genvar s = 0; s < RootW; s++) begin : g_stage
    localparam int unsigned K = RootW - 1 - s;
    logic [RW-1:0] rs;
    logic [RW-1:0] t;

    always_comb begin
      rs = {r[s][RW-3:0], n[s][2*K+1 -: 2]};
      t  = {1'b0, q[s], 2'b01};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s+1] <= 1'b0;
      end else if (en) begin
        v[s+1] <= v[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n[s+1]  <= n[s];
        ax[s+1] <= ax[s];
        ay[s+1] <= ay[s];
        sd[s+1] <= sd[s];
        if (rs >= t) begin
          r[s+1] <= rs - t;
          q[s+1] <= {q[s][RootW-2:0], 1'b1};
        end else begin
          r[s+1] <= rs;
          q[s+1] <= {q[s][RootW-2:0], 1'b0};
        end
      end
    end
  end

  assign o_v    = v[RootW];
  assign o_len  = q[RootW];
  assign o_ax   = ax[RootW];
  assign o_ay   = ay[RootW];
  assign o_side = sd[RootW];

endmodule

`default_nettype wire

/* src/wlq_div.sv */
// two-lane pipelined restoring divider for the unit normal, one quotient bit per stage
// uses wlq_pkg
`default_nettype none

module wlq_div import wlq_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_v,
  input  wire logic [RootW-1:0]  in_len,
  input  wire logic [NormW-1:0]  in_ax,
  input  wire logic [NormW-1:0]  in_ay,
  input  side_t                  in_side,
  output logic                   o_v,
  output logic [UnitW-1:0]       o_ux,
  output logic [UnitW-1:0]       o_uy,
  output side_t                  o_side
);

  localparam int unsigned RW = RootW + 1;

  logic              v    [0:UnitW];
  logic [RootW-1:0]  len  [0:UnitW];
  logic [RW-1:0]     rx   [0:UnitW];
  logic [RW-1:0]     ry   [0:UnitW];
  logic [UnitW-1:0]  qx   [0:UnitW];
  logic [UnitW-1:0]  qy   [0:UnitW];
  logic              bx   [0:UnitW];
  logic              by   [0:UnitW];
  side_t             sd   [0:UnitW];

  // x offset follows |dy|, y offset follows |dx|
  always_comb begin
    v[0]   = in_v;
    len[0] = in_len;
    rx[0]  = RW'(in_ay >> 1);
    ry[0]  = RW'(in_ax >> 1);
    bx[0]  = in_ay[0];
    by[0]  = in_ax[0];
    qx[0]  = '0;
    qy[0]  = '0;
    sd[0]  = in_side;
  end

  for (genvar s = 0; s < UnitW; s++) begin : g_stage
    logic [RW:0] sx;
    logic [RW:0] sy;

    always_comb begin
      sx = {rx[s], bx[s]};
      sy = {ry[s], by[s]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s+1] <= 1'b0;
      end else if (en) begin
        v[s+1] <= v[s];
      end
    end

    // only the first step takes a dividend bit, the rest shift in zeros
    always_ff @(posedge clk) begin
      if (en) begin
        len[s+1] <= len[s];
        sd[s+1]  <= sd[s];
        bx[s+1]  <= 1'b0;
        by[s+1]  <= 1'b0;
        if (sx >= (RW+1)'(len[s])) begin
          rx[s+1] <= RW'(sx - (RW+1)'(len[s]));
          qx[s+1] <= {qx[s][UnitW-2:0], 1'b1};
        end else begin
          rx[s+1] <= RW'(sx);
          qx[s+1] <= {qx[s][UnitW-2:0], 1'b0};
        end
        if (sy >= (RW+1)'(len[s])) begin
          ry[s+1] <= RW'(sy - (RW+1)'(len[s]));
          qy[s+1] <= {qy[s][UnitW-2:0], 1'b1};
        end else begin
          ry[s+1] <= RW'(sy);
          qy[s+1] <= {qy[s][UnitW-2:0], 1'b0};
        end
      end
    end
  end

  assign o_v    = v[UnitW];
  assign o_ux   = qx[UnitW];
  assign o_uy   = qy[UnitW];
  assign o_side = sd[UnitW];

endmodule

`default_nettype wire

/* src/wlq_back.sv */
// back end: offset multiply, rounding, sign and saturated corner sums
// uses wlq_pkg
`default_nettype none

module wlq_back import wlq_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_v,
  input  wire logic [UnitW-1:0]  in_ux,
  input  wire logic [UnitW-1:0]  in_uy,
  input  side_t                  in_side,
  output logic                   o_v,
  output logic signed [CoordW-1:0] corner0_x,
  output logic signed [CoordW-1:0] corner0_y,
  output logic signed [CoordW-1:0] corner1_x,
  output logic signed [CoordW-1:0] corner1_y,
  output logic signed [CoordW-1:0] corner2_x,
  output logic signed [CoordW-1:0] corner2_y,
  output logic signed [CoordW-1:0] corner3_x,
  output logic signed [CoordW-1:0] corner3_y,
  output logic                   degenerate
);

  logic                  v1, v2;
  side_t                 side1, side2;
  logic [ProdW-1:0]      px1, py1;
  logic signed [OffW-1:0] ox2, oy2;

  logic [ProdW:0]        rx, ry;
  logic [MagW-1:0]       mx, my;
  logic signed [CornerW-1:0] c0x, c0y, c1x, c1y, c2x, c2y, c3x, c3y;

  always_comb begin
    rx = (ProdW+1)'(px1) + ((ProdW+1)'(1) << (UnitSh - 1));
    ry = (ProdW+1)'(py1) + ((ProdW+1)'(1) << (UnitSh - 1));
    mx = MagW'(rx >> UnitSh);
    my = MagW'(ry >> UnitSh);
  end

  always_comb begin
    c0x = CornerW'(side2.sx) + CornerW'(ox2);
    c0y = CornerW'(side2.sy) + CornerW'(oy2);
    c1x = CornerW'(side2.sx) - CornerW'(ox2);
    c1y = CornerW'(side2.sy) - CornerW'(oy2);
    c2x = CornerW'(side2.ex) - CornerW'(ox2);
    c2y = CornerW'(side2.ey) - CornerW'(oy2);
    c3x = CornerW'(side2.ex) + CornerW'(ox2);
    c3y = CornerW'(side2.ey) + CornerW'(oy2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      o_v <= 1'b0;
    end else if (en) begin
      v1  <= in_v;
      v2  <= v1;
      o_v <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1 <= in_side;
      px1   <= ProdW'(in_ux) * ProdW'(in_side.w);
      py1   <= ProdW'(in_uy) * ProdW'(in_side.w);

      side2 <= side1;
      // zero-length segment keeps the endpoints
      if (side1.deg) begin
        ox2 <= '0;
        oy2 <= '0;
      end else begin
        ox2 <= side1.neg_x ? -signed'(OffW'(mx)) : signed'(OffW'(mx));
        oy2 <= side1.neg_y ? -signed'(OffW'(my)) : signed'(OffW'(my));
      end

      corner0_x  <= sat32(c0x);
      corner0_y  <= sat32(c0y);
      corner1_x  <= sat32(c1x);
      corner1_y  <= sat32(c1y);
      corner2_x  <= sat32(c2x);
      corner2_y  <= sat32(c2y);
      corner3_x  <= sat32(c3x);
      corner3_y  <= sat32(c3y);
      degenerate <= side2.deg;
    end
  end

endmodule

`default_nettype wire

/* src/wide_line_to_quad_unit.sv */
// top level of the wide line to quad expansion
// uses wlq_pkg, wlq_front, wlq_sqrt, wlq_div, wlq_back
//
//   channel  | handshake             | payload
//   ---------+-----------------------+------------------------------------------
//   in       | in_valid / in_stall   | start_x start_y end_x end_y line_width
//   out      | out_valid / out_stall | corner0..3 _x/_y, degenerate
//   cfg      | cfg_valid / cfg_ready | cfg_min_half_width
//
// one item per cycle while the output is not stalled; stages: 5 front, 32 square root, 31 divide, 3 back
// the square root and divider stages set the depth, one result bit per stage
// reset clears every stage valid bit and min_half_width
// a stalled result freezes the whole pipe; in_stall follows a held output
// cfg_ready is always high
`default_nettype none

module wide_line_to_quad_unit import wlq_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic signed [CoordW-1:0] start_x,
  input  wire logic signed [CoordW-1:0] start_y,
  input  wire logic signed [CoordW-1:0] end_x,
  input  wire logic signed [CoordW-1:0] end_y,
  input  wire logic [WidthW-1:0]        line_width,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [CoordW-1:0]      corner0_x,
  output logic signed [CoordW-1:0]      corner0_y,
  output logic signed [CoordW-1:0]      corner1_x,
  output logic signed [CoordW-1:0]      corner1_y,
  output logic signed [CoordW-1:0]      corner2_x,
  output logic signed [CoordW-1:0]      corner2_y,
  output logic signed [CoordW-1:0]      corner3_x,
  output logic signed [CoordW-1:0]      corner3_y,
  output logic                          degenerate,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [WidthW-1:0]        cfg_min_half_width
);

  logic              en;
  logic [WidthW-1:0] min_half_width;

  logic              f_v;
  logic [SumW-1:0]   f_n;
  logic [NormW-1:0]  f_ax, f_ay;
  side_t             f_side;

  logic              s_v;
  logic [RootW-1:0]  s_len;
  logic [NormW-1:0]  s_ax, s_ay;
  side_t             s_side;

  logic              d_v;
  logic [UnitW-1:0]  d_ux, d_uy;
  side_t             d_side;

  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_half_width <= '0;
    end else if (cfg_valid && cfg_ready) begin
      min_half_width <= cfg_min_half_width;
    end
  end

  wlq_front u_front (
    .clk, .rst, .en,
    .in_v(in_valid), .start_x, .start_y, .end_x, .end_y, .line_width,
    .min_hw(min_half_width),
    .o_v(f_v), .o_n(f_n), .o_ax(f_ax), .o_ay(f_ay), .o_side(f_side)
  );

  wlq_sqrt u_sqrt (
    .clk, .rst, .en,
    .in_v(f_v), .in_n(f_n), .in_ax(f_ax), .in_ay(f_ay), .in_side(f_side),
    .o_v(s_v), .o_len(s_len), .o_ax(s_ax), .o_ay(s_ay), .o_side(s_side)
  );

  wlq_div u_div (
    .clk, .rst, .en,
    .in_v(s_v), .in_len(s_len), .in_ax(s_ax), .in_ay(s_ay), .in_side(s_side),
    .o_v(d_v), .o_ux(d_ux), .o_uy(d_uy), .o_side(d_side)
  );

  wlq_back u_back (
    .clk, .rst, .en,
    .in_v(d_v), .in_ux(d_ux), .in_uy(d_uy), .in_side(d_side),
    .o_v(out_valid),
    .corner0_x, .corner0_y, .corner1_x, .corner1_y,
    .corner2_x, .corner2_y, .corner3_x, .corner3_y, .degenerate
  );

endmodule

`default_nettype wire

/* src/wlq_checker.sv */
// port-level checks for wide_line_to_quad_unit, bound to the top level
// uses wlq_pkg
`default_nettype none

module wlq_checker import wlq_pkg::*; (
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     in_stall,
  input wire logic                     out_valid,
  input wire logic                     out_stall,
  input wire logic                     cfg_ready,
  input wire logic signed [CoordW-1:0] corner0_x,
  input wire logic signed [CoordW-1:0] corner0_y,
  input wire logic signed [CoordW-1:0] corner1_x,
  input wire logic signed [CoordW-1:0] corner1_y,
  input wire logic signed [CoordW-1:0] corner2_x,
  input wire logic signed [CoordW-1:0] corner2_y,
  input wire logic signed [CoordW-1:0] corner3_x,
  input wire logic signed [CoordW-1:0] corner3_y,
  input wire logic                     degenerate
);

  // input is held back only by a stalled output item
  a_stall_src: assert property (@(posedge clk) in_stall == (out_valid && out_stall))
    else $error("in_stall does not follow output stall");

  // zero-length segment gives paired corners
  a_degen: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> corner0_x == corner1_x && corner0_y == corner1_y &&
      corner2_x == corner3_x && corner2_y == corner3_y)
    else $error("degenerate item with split corners");

  a_cfg_rdy: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("config port not ready");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled output item dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(corner0_x) && $stable(corner3_y))
    else $error("stalled output item changed");

endmodule

bind wide_line_to_quad_unit wlq_checker u_wlq_checker (
  .clk, .rst, .in_stall, .out_valid, .out_stall, .cfg_ready,
  .corner0_x, .corner0_y, .corner1_x, .corner1_y,
  .corner2_x, .corner2_y, .corner3_x, .corner3_y, .degenerate
);

`default_nettype wire
